[rtl/sht_pkg.sv]
`timescale 1ns / 1ps

package sht_pkg;

   // Table geometry.
   localparam int CAPACITY = 64;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // Field widths of the stream channels.
   localparam int MODE_W      = 3;
   localparam int SIZE_W      = 32;
   localparam int ADDR_W      = 32;
   localparam int HOLE_IDX_W  = 6;
   localparam int STATUS_W    = 2;
   localparam int ENTRY_IDX_W = 6;
   localparam int ENTRY_CNT_W = 7;
   localparam int REQ_DATA_W  = 72;
   localparam int RSP_DATA_W  = 80;
   localparam int RSP_USER_W  = 3;

   // Operation codes carried in the request tuser field.
   typedef enum logic [MODE_W-1:0] {
      MODE_INSERT  = 3'd0,
      MODE_RM_ADDR = 3'd1,
      MODE_FIND    = 3'd2,
      MODE_LOOKUP  = 3'd3,
      MODE_RM_IDX  = 3'd4
   } mode_type;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK   = 2'd0,
      STATUS_FULL = 2'd1,
      STATUS_MISS = 2'd2
   } status_type;

   // One table entry.
   typedef struct packed {
      logic [SIZE_W-1:0] size;
      logic [ADDR_W-1:0] addr;
   } hole_type;

   // Compare flags that a cell shows to its neighbours.
   typedef struct packed {
      logic ge;
      logic gt;
      logic eq;
   } cell_flags_type;

   // Candidate marks for the result selection.
   typedef struct packed {
      logic eq;
      logic gt;
      logic am;
   } cell_hit_type;

   // Command strobes shared by every cell.
   typedef struct packed {
      logic capture;
      logic ins;
      logic rm_addr;
      logic rm_idx;
   } cell_cmd_type;

endpackage

[rtl/sht_cell.sv]
`timescale 1ns / 1ps

module sht_cell
   import sht_pkg::*;
(
   input  logic           clock,
   input  cell_cmd_type   cmd,
   input  hole_type       req_hole,
   input  hole_type       new_hole,
   input  logic           occupied,
   input  logic           idx_ge,
   input  hole_type       left_data,
   input  cell_flags_type left_flags,
   input  hole_type       right_data,
   input  logic           right_gt,
   input  logic           seen_in,
   output hole_type       data,
   output cell_flags_type flags,
   output cell_hit_type   hit,
   output logic           seen_out
);

   hole_type       data_ff;
   hole_type       data_in;
   cell_flags_type flags_ff;
   logic           am_ff;

   // Compare the entry with the incoming request when a transaction is taken.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         flags_ff.ge <= occupied && (data_ff.size >= req_hole.size);
         flags_ff.gt <= occupied && (data_ff.size >  req_hole.size);
         flags_ff.eq <= occupied && (data_ff.size == req_hole.size);
         am_ff       <= occupied && (data_ff.addr == req_hole.addr);
      end
   end

   // The address match ripples along the row so that only the first one counts.
   assign seen_out = seen_in | am_ff;

   // Candidates: first equal size, last larger size, first address match.
   assign hit.eq = flags_ff.eq && !left_flags.eq;
   assign hit.gt = flags_ff.gt && !right_gt;
   assign hit.am = am_ff && !seen_in;

   // Insert shifts right behind the insertion point; removal shifts left from the gap.
   always_comb begin
      data_in = data_ff;
      if (cmd.ins) begin
         if (!left_flags.ge) begin
            data_in = left_data;
         end else if (!flags_ff.ge) begin
            data_in = new_hole;
         end
      end else if (cmd.rm_addr && seen_out) begin
         data_in = right_data;
      end else if (cmd.rm_idx && idx_ge) begin
         data_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data  = data_ff;
   assign flags = flags_ff;

endmodule

[rtl/sorted_hole_table_best_fit_top.sv]
`timescale 1ns / 1ps

// A request is compared in the row of entry cells when it is taken; the shift
// and the answer follow in the evaluation state, which waits while the last
// result is still held. A new request is taken only once the answer is loaded.
// Reset clears the hole count, the control state and the result valid flag;
// the entry contents are not cleared and are only read below the count.

module sorted_hole_table_best_fit_top
   import sht_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // hole_size [31:0], hole_address [63:32], hole_index [69:64], zeros [71:70]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // mode [2:0]
   input  logic [MODE_W-1:0]     req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // entry_index [5:0], entry_size [37:6], entry_address [69:38],
   // entry_count [76:70], zeros [79:77]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // status [1:0], found [2]
   output logic [RSP_USER_W-1:0] rsp_tuser
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EVAL = 2'b10
   } state_type;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]      count_ff, count_in;
   mode_type              mode_ff;
   hole_type              hole_ff;
   logic [HOLE_IDX_W-1:0] idx_ff;

   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic [RSP_USER_W-1:0] rsp_tuser_ff, rsp_tuser_in;

   logic         req_accept;
   logic         commit;
   logic         full;
   logic         idx_ok;
   logic         any_eq;
   logic         found;
   status_type   status;
   hole_type     req_hole;
   cell_cmd_type cmd;

   hole_type       cell_data  [CAPACITY];
   cell_flags_type cell_flags [CAPACITY];
   cell_hit_type   cell_hit   [CAPACITY];
   logic [CAPACITY:0]   seen;
   logic [CAPACITY-1:0] eq_vec;
   logic [CAPACITY-1:0] sel_vec;

   logic [IDX_W-1:0]  sel_idx;
   hole_type          sel_hole;

   // Handshake and control.
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign commit     = (state_ff == ST_EVAL) && (!rsp_valid_ff || rsp_tready);

   assign req_hole.size = req_tdata[31:0];
   assign req_hole.addr = req_tdata[63:32];

   assign full   = (count_ff == CNT_W'(CAPACITY));
   assign idx_ok = (32'(idx_ff) < 32'(count_ff));

   assign cmd.capture = req_accept;
   assign cmd.ins     = commit && (mode_ff == MODE_INSERT) && !full;
   assign cmd.rm_addr = commit && (mode_ff == MODE_RM_ADDR);
   assign cmd.rm_idx  = commit && (mode_ff == MODE_RM_IDX) && idx_ok;

   // Latch the request fields for the evaluation state.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         mode_ff <= mode_type'(req_tuser);
         hole_ff <= req_hole;
         idx_ff  <= req_tdata[69:64];
      end
   end

   // Row of entry cells.
   assign seen[0] = 1'b0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      hole_type       left_data;
      cell_flags_type left_flags;
      hole_type       right_data;
      logic           right_gt;

      if (i == 0) begin : g_first
         assign left_data  = hole_ff;
         assign left_flags = '{ge: 1'b1, gt: 1'b1, eq: 1'b0};
      end else begin : g_inner_left
         assign left_data  = cell_data[i-1];
         assign left_flags = cell_flags[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_data = cell_data[i];
         assign right_gt   = 1'b0;
      end else begin : g_inner_right
         assign right_data = cell_data[i+1];
         assign right_gt   = cell_flags[i+1].gt;
      end

      sht_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .req_hole   (req_hole),
         .new_hole   (hole_ff),
         .occupied   (32'(i) < 32'(count_ff)),
         .idx_ge     (32'(i) >= 32'(idx_ff)),
         .left_data  (left_data),
         .left_flags (left_flags),
         .right_data (right_data),
         .right_gt   (right_gt),
         .seen_in    (seen[i]),
         .data       (cell_data[i]),
         .flags      (cell_flags[i]),
         .hit        (cell_hit[i]),
         .seen_out   (seen[i+1])
      );

      assign eq_vec[i] = cell_flags[i].eq;
   end

   assign any_eq = |eq_vec;

   // Pick the answering cell: an exact fit wins over the smallest larger hole.
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         case (mode_ff)
            MODE_FIND:   sel_vec[i] = any_eq ? cell_hit[i].eq : cell_hit[i].gt;
            MODE_LOOKUP: sel_vec[i] = cell_hit[i].am;
            default:     sel_vec[i] = 1'b0;
         endcase
      end
   end

   assign found = |sel_vec;

   // One-hot read-out of the selected entry.
   always_comb begin
      sel_idx  = '0;
      sel_hole = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (sel_vec[i]) begin
            sel_idx  = sel_idx | IDX_W'(i);
            sel_hole = sel_hole | cell_data[i];
         end
      end
   end

   // Status of the current transaction.
   always_comb begin
      case (mode_ff)
         MODE_INSERT:  status = full ? STATUS_FULL : STATUS_OK;
         MODE_RM_ADDR: status = seen[CAPACITY] ? STATUS_OK : STATUS_MISS;
         MODE_FIND:    status = found ? STATUS_OK : STATUS_MISS;
         MODE_LOOKUP:  status = found ? STATUS_OK : STATUS_MISS;
         MODE_RM_IDX:  status = idx_ok ? STATUS_OK : STATUS_MISS;
         default:      status = STATUS_MISS;
      endcase
   end

   // Hole count after the step.
   always_comb begin
      count_in = count_ff;
      if (cmd.ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if ((cmd.rm_addr && seen[CAPACITY]) || cmd.rm_idx) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // Result transaction contents.
   always_comb begin
      rsp_tdata_in        = '0;
      rsp_tdata_in[5:0]   = found ? ENTRY_IDX_W'(sel_idx) : '0;
      rsp_tdata_in[37:6]  = sel_hole.size;
      rsp_tdata_in[69:38] = sel_hole.addr;
      rsp_tdata_in[76:70] = ENTRY_CNT_W'(count_in);
      rsp_tuser_in        = {found, status};
   end

   // Sequencer.
   always_comb begin
      case (state_ff)
         ST_IDLE: state_in = req_accept ? ST_EVAL : ST_IDLE;
         ST_EVAL: state_in = commit ? ST_IDLE : ST_EVAL;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_tdata_ff <= rsp_tdata_in;
         rsp_tuser_ff <= rsp_tuser_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   // Checks on the block's own logic.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("hole count beyond capacity");

   a_one_answer: assert property (@(posedge clock) disable iff (reset)
      $onehot0(sel_vec))
      else $error("more than one cell selected");

   a_eval_follows: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_EVAL))
      else $error("evaluation did not follow an accepted transaction");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      cmd.ins |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("insert did not grow the table");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      (commit && found) |=> (rsp_tuser_ff[1:0] == STATUS_OK))
      else $error("found entry reported with a failure status");

endmodule

[dv/sorted_hole_table_best_fit_top_tb.sv]
`timescale 1ns / 1ps

module sorted_hole_table_best_fit_top_tb;
   import sht_pkg::*;

   // Mode codes that the block does not implement; they must answer a miss.
   localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
   localparam logic [MODE_W-1:0] MODE_SPARE_MID   = 3'd6;
   localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;

   localparam int          CLOCK_HALF  = 5;
   localparam int          CYCLE_LIMIT = 400000;
   localparam int          DRAIN_WAIT  = 20;
   localparam logic [31:0] SIZE_MAX    = 32'hFFFF_FFFF;

   // One request transaction, field by field.
   typedef struct {
      logic [MODE_W-1:0]     mode;
      logic [SIZE_W-1:0]     size;
      logic [ADDR_W-1:0]     addr;
      logic [HOLE_IDX_W-1:0] index;
   } hole_request_type;

   // One response transaction, field by field.
   typedef struct {
      logic [STATUS_W-1:0]    status;
      logic                   found;
      logic [ENTRY_IDX_W-1:0] index;
      logic [SIZE_W-1:0]      size;
      logic [ADDR_W-1:0]      addr;
      logic [ENTRY_CNT_W-1:0] count;
   } hole_answer_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [MODE_W-1:0]     req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;

   // Shadow copy of the hole table, largest size first.
   logic [SIZE_W-1:0] shadow_size [CAPACITY];
   logic [ADDR_W-1:0] shadow_addr [CAPACITY];
   int                shadow_count = 0;

   hole_answer_type pending_answers[$];
   int              error_count     = 0;
   int              cycle_count     = 0;
   int              sender_idle_pct = 0;
   int              rsp_stall_pct   = 0;
   int              rsp_hold_left   = 0;

   sorted_hole_table_best_fit_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #CLOCK_HALF clock = ~clock;

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Receiver: a long hold-off when asked, otherwise random stalls.
   always @(negedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_tready    <= 1'b0;
         rsp_hold_left <= rsp_hold_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Lowest position holding an address, or -1 when it is absent.
   function automatic int shadow_find_address(logic [ADDR_W-1:0] addr);
      int pos;
      pos = -1;
      for (int k = shadow_count - 1; k >= 0; k--) begin
         if (shadow_addr[k] == addr) pos = k;
      end
      return pos;
   endfunction

   // Remove one entry and close the gap.
   function automatic void shadow_drop(int pos);
      for (int k = pos; k + 1 < shadow_count; k++) begin
         shadow_size[k] = shadow_size[k + 1];
         shadow_addr[k] = shadow_addr[k + 1];
      end
      shadow_count--;
   endfunction

   // Apply one request to the shadow table and work out its answer.
   function automatic hole_answer_type predict_answer(hole_request_type rq);
      hole_answer_type ans;
      int              pos;
      int              k;
      bit              done;
      ans.status = STATUS_MISS;
      ans.found  = 1'b0;
      ans.index  = '0;
      ans.size   = '0;
      ans.addr   = '0;
      pos        = -1;
      done       = 1'b0;
      case (rq.mode)
         MODE_INSERT: begin
            if (shadow_count >= CAPACITY) begin
               ans.status = STATUS_FULL;
            end else begin
               // Shift smaller holes up; equal sizes keep the older entry first.
               k = shadow_count;
               while (k > 0 && shadow_size[k - 1] < rq.size) begin
                  shadow_size[k] = shadow_size[k - 1];
                  shadow_addr[k] = shadow_addr[k - 1];
                  k--;
               end
               shadow_size[k] = rq.size;
               shadow_addr[k] = rq.addr;
               shadow_count++;
               ans.status = STATUS_OK;
            end
         end
         MODE_RM_ADDR: begin
            pos = shadow_find_address(rq.addr);
            if (pos >= 0) begin
               shadow_drop(pos);
               ans.status = STATUS_OK;
            end
            pos = -1;
         end
         MODE_FIND: begin
            // An exact size wins; otherwise the last entry still larger.
            for (k = 0; k < shadow_count && !done; k++) begin
               if (shadow_size[k] == rq.size) begin
                  pos  = k;
                  done = 1'b1;
               end else if (shadow_size[k] > rq.size) begin
                  pos = k;
               end else begin
                  done = 1'b1;
               end
            end
         end
         MODE_LOOKUP: begin
            pos = shadow_find_address(rq.addr);
         end
         MODE_RM_IDX: begin
            if (rq.index < shadow_count) begin
               shadow_drop(int'(rq.index));
               ans.status = STATUS_OK;
            end
         end
         default: ;
      endcase
      if (pos >= 0) begin
         ans.status = STATUS_OK;
         ans.found  = 1'b1;
         ans.index  = pos[ENTRY_IDX_W-1:0];
         ans.size   = shadow_size[pos];
         ans.addr   = shadow_addr[pos];
      end
      ans.count = shadow_count[ENTRY_CNT_W-1:0];
      return ans;
   endfunction

   function automatic hole_request_type make_request(logic [MODE_W-1:0] mode,
                                                     logic [SIZE_W-1:0] size,
                                                     logic [ADDR_W-1:0] addr,
                                                     logic [HOLE_IDX_W-1:0] index);
      hole_request_type rq;
      rq.mode  = mode;
      rq.size  = size;
      rq.addr  = addr;
      rq.index = index;
      return rq;
   endfunction

   // A request biased towards hits, equal sizes and duplicate addresses.
   function automatic hole_request_type random_request();
      hole_request_type rq;
      int               pick;
      int               ins_weight;
      rq.size    = $urandom;
      rq.addr    = $urandom;
      rq.index   = HOLE_IDX_W'($urandom_range(63, 0));
      ins_weight = (shadow_count < 16) ? 45 : ((shadow_count > 56) ? 15 : 30);
      pick       = $urandom_range(99);
      if (pick < 3) begin
         rq.mode = MODE_W'($urandom_range(MODE_SPARE_LAST, MODE_SPARE_FIRST));
      end else if (pick < 3 + ins_weight) begin
         rq.mode = MODE_INSERT;
         case ($urandom_range(3))
            0, 1: rq.size = $urandom_range(15, 0);
            2:    rq.size = $urandom_range(1) ? SIZE_MAX : '0;
            default: ;
         endcase
         if ($urandom_range(4) < 2) rq.addr = $urandom_range(7, 0);
      end else begin
         case ($urandom_range(3))
            0: rq.mode = MODE_RM_ADDR;
            1: rq.mode = MODE_FIND;
            2: rq.mode = MODE_LOOKUP;
            default: rq.mode = MODE_RM_IDX;
         endcase
         if (shadow_count > 0) begin
            if ($urandom_range(9) < 7)
               rq.addr = shadow_addr[$urandom_range(shadow_count - 1, 0)];
            if (rq.mode == MODE_FIND && $urandom_range(1))
               rq.size = shadow_size[$urandom_range(shadow_count - 1, 0)]
                         + $urandom_range(1, 0);
            if (rq.mode == MODE_RM_IDX && $urandom_range(4) != 0)
               rq.index = HOLE_IDX_W'($urandom_range(shadow_count - 1, 0));
         end
         if (rq.mode == MODE_FIND && $urandom_range(3) == 0)
            rq.size = $urandom_range(16, 0);
      end
      return rq;
   endfunction

   // Offer one request, with random gaps, and log its answer once it is taken.
   task automatic send_request(input hole_request_type rq);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= REQ_DATA_W'({$urandom, $urandom, $urandom});
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W - SIZE_W - ADDR_W - HOLE_IDX_W){1'b0}},
                     rq.index, rq.addr, rq.size};
      req_tuser  <= rq.mode;
      do @(posedge clock); while (!req_tready);
      pending_answers.push_back(predict_answer(rq));
   endtask

   task automatic release_request_channel();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic wait_all_answered();
      release_request_channel();
      while (pending_answers.size() != 0) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [31:0] expected,
                              input logic [31:0] actual);
      if (expected !== actual) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, expected, actual);
         error_count++;
      end
   endtask

   // Compare each response transaction with the oldest expectation.
   always @(posedge clock) begin : check_answers
      hole_answer_type expected;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_answers.size() == 0) begin
            $error("Response transaction with no request outstanding: tdata 0x%0h",
                   rsp_tdata);
            error_count++;
         end else begin
            expected = pending_answers.pop_front();
            check_field("status", 32'(expected.status), 32'(rsp_tuser[1:0]));
            check_field("found", 32'(expected.found), 32'(rsp_tuser[2]));
            check_field("entry_index", 32'(expected.index), 32'(rsp_tdata[5:0]));
            check_field("entry_size", expected.size, rsp_tdata[37:6]);
            check_field("entry_address", expected.addr, rsp_tdata[69:38]);
            check_field("entry_count", 32'(expected.count), 32'(rsp_tdata[76:70]));
         end
      end
   end

   // Empty-table misses, extreme sizes and addresses, ties and every mode.
   task automatic test_directed();
      sender_idle_pct = 0;
      rsp_stall_pct   = 0;
      send_request(make_request(MODE_FIND, 32'd5, '0, '0));
      send_request(make_request(MODE_RM_ADDR, '0, '0, '0));
      send_request(make_request(MODE_RM_IDX, '0, '0, '0));
      send_request(make_request(MODE_LOOKUP, '0, SIZE_MAX, '1));
      send_request(make_request(MODE_INSERT, '0, '0, '1));
      send_request(make_request(MODE_INSERT, SIZE_MAX, SIZE_MAX, '0));
      send_request(make_request(MODE_INSERT, 32'd100, 32'h1000, '0));
      send_request(make_request(MODE_INSERT, 32'd100, 32'h2000, '0));
      send_request(make_request(MODE_INSERT, 32'd50, 32'h1000, '0));
      send_request(make_request(MODE_FIND, 32'd100, '0, '0));
      send_request(make_request(MODE_FIND, 32'd60, '0, '0));
      send_request(make_request(MODE_FIND, '0, '0, '0));
      send_request(make_request(MODE_FIND, SIZE_MAX, '0, '0));
      send_request(make_request(MODE_LOOKUP, '0, 32'h1000, '0));
      send_request(make_request(MODE_RM_ADDR, '0, 32'h1000, '0));
      send_request(make_request(MODE_LOOKUP, '0, 32'h1000, '0));
      send_request(make_request(MODE_RM_IDX, '0, '0, 6'd63));
      send_request(make_request(MODE_RM_IDX, '0, '0, 6'd4));
      send_request(make_request(MODE_RM_IDX, '0, '0, 6'd3));
      send_request(make_request(MODE_SPARE_FIRST, SIZE_MAX, SIZE_MAX, '1));
      send_request(make_request(MODE_SPARE_MID, '0, '0, '0));
      send_request(make_request(MODE_SPARE_LAST, 32'd100, 32'h2000, 6'd1));
      send_request(make_request(MODE_RM_IDX, '0, '0, '0));
      send_request(make_request(MODE_FIND, SIZE_MAX, '0, '0));
      wait_all_answered();
   endtask

   // Fill the table, insert into a full table, then drain most of it.
   task automatic test_full_table();
      sender_idle_pct = 15;
      rsp_stall_pct   = 15;
      while (shadow_count < CAPACITY)
         send_request(make_request(MODE_INSERT, $urandom_range(20, 0), $urandom,
                                   HOLE_IDX_W'($urandom_range(63, 0))));
      send_request(make_request(MODE_INSERT, SIZE_MAX, $urandom, '0));
      send_request(make_request(MODE_INSERT, '0, $urandom, '1));
      send_request(make_request(MODE_LOOKUP, '0, shadow_addr[CAPACITY - 1], '0));
      send_request(make_request(MODE_RM_IDX, '0, '0, 6'd63));
      send_request(make_request(MODE_INSERT, 32'd7, SIZE_MAX, '0));
      send_request(make_request(MODE_FIND, '0, '0, '0));
      while (shadow_count > 8)
         send_request(make_request(MODE_RM_IDX, $urandom, $urandom,
                                   HOLE_IDX_W'($urandom_range(shadow_count - 1, 0))));
      wait_all_answered();
   endtask

   // Random mix of operations under one idling profile.
   task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                    input int count);
      sender_idle_pct = idle_pct;
      rsp_stall_pct   = stall_pct;
      repeat (count) send_request(random_request());
      wait_all_answered();
   endtask

   // Long receiver hold-off while requests keep coming, then a full drain.
   task automatic test_backpressure();
      sender_idle_pct = 0;
      rsp_stall_pct   = 0;
      @(negedge clock);
      rsp_hold_left = 300;
      repeat (40) send_request(random_request());
      wait_all_answered();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_full_table();
      test_random_phase(0, 0, 150);
      test_random_phase(54, 0, 150);
      test_random_phase(0, 54, 150);
      test_random_phase(15, 15, 150);
      test_backpressure();
      // Let any stray response transaction show up before the verdict.
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0 && pending_answers.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
